@@ hw/rtl/sld_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment LCD display package
// Shared constants, codes, the seven-segment table and the divide-by-ten
// result type used by the display store and its arithmetic unit.
// ----------------------------------------------------------------------------
package sld_pkg;

    // Store geometry and word widths
    localparam int STORE_BYTES = 16;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int VALUE_W     = 32;
    localparam int WORK_W      = 20;
    localparam int WORD_W      = 9;
    localparam int SEG_CODES   = 26;

    // Write command 101 followed by address 0
    localparam logic [WORD_W-1:0] FRAME_HEADER = 9'd320;

    // Saturation limits of the two number areas
    localparam logic [WORK_W-1:0] LOW_AREA_MAX  = 20'd99999;
    localparam logic [WORK_W-1:0] HIGH_AREA_MAX = 20'd999999;

    // Digit placement: top byte and digit count of each area
    localparam logic [IDX_W-1:0] LOW_AREA_TOP   = 4'd9;
    localparam logic [IDX_W-1:0] HIGH_AREA_TOP  = 4'd15;
    localparam logic [2:0]       LOW_AREA_DIGS  = 3'd5;
    localparam logic [2:0]       HIGH_AREA_DIGS = 3'd6;

    localparam logic [7:0] SEG_ALL_ON  = 8'hFF;
    localparam logic [7:0] SEG_ALL_OFF = 8'h00;

    // Action codes
    typedef logic [2:0] action_t;
    localparam action_t ACT_LOW_AREA  = 3'd0;
    localparam action_t ACT_HIGH_AREA = 3'd1;
    localparam action_t ACT_FILL_CHAR = 3'd2;
    localparam action_t ACT_ALL_ON    = 3'd3;
    localparam action_t ACT_ALL_OFF   = 3'd4;
    localparam action_t ACT_BOOT      = 3'd5;
    localparam action_t ACT_REFRESH   = 3'd6;

    // Quotient and remainder of one divide-by-ten step
    typedef struct packed {
        logic [WORK_W-1:0] quot;
        logic [3:0]        rem;
    } div10_t;

    // Seven-segment table, A in bit 0 through G in bit 6; codes past the
    // table give the blank pattern.
    function automatic logic [7:0] seg_code(input logic [4:0] code);
        logic [7:0] seg;
        case (code)
            5'd0:    seg = 8'h3F;
            5'd1:    seg = 8'h06;
            5'd2:    seg = 8'h5B;
            5'd3:    seg = 8'h4F;
            5'd4:    seg = 8'h66;
            5'd5:    seg = 8'h6D;
            5'd6:    seg = 8'h7D;
            5'd7:    seg = 8'h07;
            5'd8:    seg = 8'h7F;
            5'd9:    seg = 8'h6F;
            5'd10:   seg = 8'h39;
            5'd11:   seg = 8'h77;
            5'd12:   seg = 8'h38;
            5'd13:   seg = 8'h73;
            5'd14:   seg = 8'h67;
            5'd15:   seg = 8'h71;
            5'd16:   seg = 8'h3E;
            5'd17:   seg = 8'h79;
            5'd18:   seg = 8'h70;
            5'd19:   seg = 8'h40;
            5'd20:   seg = 8'h7C;
            5'd21:   seg = 8'h5C;
            5'd22:   seg = 8'h78;
            5'd23:   seg = 8'h5E;
            5'd24:   seg = 8'h37;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

@@ hw/rtl/sld_div10.sv @@
// ----------------------------------------------------------------------------
// Divide-by-ten unit
// Splits a 20-bit value into quotient and remainder by ten using a scaled
// reciprocal multiply and a shift-add back-multiplication.
// ----------------------------------------------------------------------------
module sld_div10 (
    input  logic [sld_pkg::WORK_W-1:0] dividend,
    output sld_pkg::div10_t            result
);
    import sld_pkg::*;

    // ceil(2^23 / 10); exact for every dividend below 2^22
    localparam logic [23:0] RECIP_10 = 24'hCCCCD;

    logic [WORK_W+23:0] product;
    logic [WORK_W-1:0]  quot;
    logic [WORK_W-1:0]  times_ten;

    // Quotient from the reciprocal product
    assign product = {24'd0, dividend} * {{WORK_W{1'b0}}, RECIP_10};
    assign quot    = product[WORK_W+22:23];

    // Remainder is the dividend less ten times the quotient
    assign times_ten = {quot[WORK_W-4:0], 3'b000} + {quot[WORK_W-2:0], 1'b0};

    assign result.quot = quot;
    assign result.rem  = 4'(dividend - times_ten);

endmodule

@@ hw/rtl/segment_lcd_number_display.sv @@
// ----------------------------------------------------------------------------
// Segment LCD number display
// Holds a 16-byte segment store and produces write frames for a segment
// LCD controller, one frame word per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one command per transfer: the action in
//   s_tuser and the value in s_tdata. s_tready is high only while the
//   sequencer is idle, so one command is worked on at a time.
//   Number actions run one digit per cycle through the shared divide-by-ten
//   unit: five digits for the low area, six for the high area. Fill, all-on,
//   all-off and boot write one store byte per cycle, all 16 store bytes.
//   Frame actions then send 17 words on the output channel: the header,
//   flagged in m_tuser, then store bytes 15 down to 0, with m_tlast on the
//   final byte. For a refresh, the state register enters the send state and
//   the output register, once free, loads the header to raise m_tvalid; a
//   fill first writes the whole store and then does the same.
//   The output register holds a word while m_tready is low, and the frame
//   sequencer waits; the next command may be taken while the final word
//   still waits to be taken.
//   Reset clears the store to all zero and empties the output register.
// ----------------------------------------------------------------------------
module segment_lcd_number_display (
    input  logic        aclk,
    input  logic        aresetn,
    // Command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] action
    // Frame word channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [8:0] frame_word, [15:9] zero
    output logic [0:0]  m_tuser,   // [0] is_header
    output logic        m_tlast
);
    import sld_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_FILL,
        ST_SEND
    } state_t;

    state_t             state_reg, state_next;
    logic [7:0]         store_reg [STORE_BYTES];
    logic [7:0]         store_next [STORE_BYTES];
    logic [WORK_W-1:0]  work_reg, work_next;
    logic [2:0]         digits_reg, digits_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [7:0]         fill_byte_reg, fill_byte_next;
    logic               boot_reg, boot_next;
    logic               emit_reg, emit_next;
    logic               m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]  m_word_reg, m_word_next;
    logic               m_header_reg, m_header_next;
    logic               m_last_reg, m_last_next;

    div10_t             div_out;
    logic               accept;
    logic [IDX_W-1:0]   send_idx;
    logic               out_free;

    // Shared divide-by-ten unit
    sld_div10 u_div10 (
        .dividend (work_reg),
        .result   (div_out)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    // Frame word k (1..16) carries store byte 16 - k
    assign send_idx = IDX_W'(STORE_BYTES - int'(idx_reg));

    // Sequencer next-state logic
    always_comb begin
        state_next     = state_reg;
        store_next     = store_reg;
        work_next      = work_reg;
        digits_next    = digits_reg;
        idx_next       = idx_reg;
        fill_byte_next = fill_byte_reg;
        boot_next      = boot_reg;
        emit_next      = emit_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_word_next    = m_word_reg;
        m_header_next  = m_header_reg;
        m_last_next    = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next = '0;
                    case (s_tuser)
                        ACT_LOW_AREA: begin
                            work_next   = (s_tdata > VALUE_W'(LOW_AREA_MAX)) ?
                                          LOW_AREA_MAX : s_tdata[WORK_W-1:0];
                            idx_next    = CNT_W'(LOW_AREA_TOP);
                            digits_next = LOW_AREA_DIGS;
                            state_next  = ST_DIGIT;
                        end
                        ACT_HIGH_AREA: begin
                            work_next   = (s_tdata > VALUE_W'(HIGH_AREA_MAX)) ?
                                          HIGH_AREA_MAX : s_tdata[WORK_W-1:0];
                            idx_next    = CNT_W'(HIGH_AREA_TOP);
                            digits_next = HIGH_AREA_DIGS;
                            state_next  = ST_DIGIT;
                        end
                        ACT_FILL_CHAR: begin
                            fill_byte_next = (s_tdata < VALUE_W'(SEG_CODES)) ?
                                             seg_code(s_tdata[4:0]) : SEG_ALL_OFF;
                            boot_next      = 1'b0;
                            emit_next      = 1'b1;
                            state_next     = ST_FILL;
                        end
                        ACT_ALL_ON: begin
                            fill_byte_next = SEG_ALL_ON;
                            boot_next      = 1'b0;
                            emit_next      = 1'b1;
                            state_next     = ST_FILL;
                        end
                        ACT_ALL_OFF: begin
                            fill_byte_next = SEG_ALL_OFF;
                            boot_next      = 1'b0;
                            emit_next      = 1'b1;
                            state_next     = ST_FILL;
                        end
                        ACT_BOOT: begin
                            boot_next  = 1'b1;
                            emit_next  = 1'b0;
                            state_next = ST_FILL;
                        end
                        ACT_REFRESH: begin
                            state_next = ST_SEND;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // One decimal digit per cycle, least significant first
            ST_DIGIT: begin
                store_next[idx_reg[IDX_W-1:0]] = seg_code({1'b0, div_out.rem});
                work_next   = div_out.quot;
                idx_next    = idx_reg - 1'b1;
                digits_next = digits_reg - 1'b1;
                if (digits_reg == 3'd1) begin
                    state_next = ST_IDLE;
                end
            end

            // One store byte per cycle, index 0 upward
            ST_FILL: begin
                store_next[idx_reg[IDX_W-1:0]] = boot_reg ?
                    seg_code(idx_reg) : fill_byte_reg;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CNT_W'(STORE_BYTES - 1)) begin
                    idx_next   = '0;
                    state_next = emit_reg ? ST_SEND : ST_IDLE;
                end
            end

            // Header, then store bytes from the top down
            ST_SEND: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_header_next = (idx_reg == '0);
                    m_word_next   = (idx_reg == '0) ? FRAME_HEADER :
                                    {1'b0, store_reg[send_idx]};
                    m_last_next   = (idx_reg == CNT_W'(STORE_BYTES));
                    idx_next      = idx_reg + 1'b1;
                    if (idx_reg == CNT_W'(STORE_BYTES)) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, store and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            digits_reg  <= '0;
            boot_reg    <= 1'b0;
            emit_reg    <= 1'b0;
            for (int i = 0; i < STORE_BYTES; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            digits_reg  <= digits_next;
            boot_reg    <= boot_next;
            emit_reg    <= emit_next;
            store_reg   <= store_next;
        end
        work_reg      <= work_next;
        fill_byte_reg <= fill_byte_next;
        m_word_reg    <= m_word_next;
        m_header_reg  <= m_header_next;
        m_last_reg    <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_word_reg};
    assign m_tuser  = m_header_reg;
    assign m_tlast  = m_last_reg;

    // A header transfer always carries the command and address word
    a_header_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_header_reg) |-> (m_word_reg == FRAME_HEADER && !m_last_reg))
        else $error("header word malformed");

    // A refresh command starts the frame sequencer on the next cycle
    a_refresh_sends: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == ACT_REFRESH) |=> (state_reg == ST_SEND && idx_reg == '0))
        else $error("refresh did not start a frame");

    // Digit conversion never runs below byte 5, the lowest byte of the low area
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIGIT) |-> (digits_reg != 3'd0 && idx_reg >= CNT_W'(5)))
        else $error("digit sequencer out of range");

    // The remainder of the shared unit is always a decimal digit
    a_digit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIGIT) |-> (div_out.rem < 4'd10))
        else $error("divide-by-ten remainder out of range");

endmodule

@@ dv/segment_lcd_number_display_tb.sv @@
// ----------------------------------------------------------------------------
// Segment LCD number display testbench
// Sends display commands on the command stream and checks every frame word
// against a local copy of the segment store. A short directed list covers
// the number extremes, saturation, the fill character edge cases, all-on,
// all-off, boot and the unused action. A long random run follows, with
// random gaps on both sides and one long output hold-off that backs the
// block up into its command channel.
// ----------------------------------------------------------------------------
module segment_lcd_number_display_tb;

    import sld_pkg::action_t;
    import sld_pkg::ACT_LOW_AREA;
    import sld_pkg::ACT_HIGH_AREA;
    import sld_pkg::ACT_FILL_CHAR;
    import sld_pkg::ACT_ALL_ON;
    import sld_pkg::ACT_ALL_OFF;
    import sld_pkg::ACT_BOOT;
    import sld_pkg::ACT_REFRESH;

    // The one action code the block does not use
    localparam action_t ACT_UNUSED = 3'd7;

    localparam int          NUM_BYTES   = 16;
    localparam int          GLYPHS      = 26;
    localparam int          BLANK_IDX   = 25;
    localparam logic [8:0]  HDR_WORD    = 9'd320;
    localparam logic [31:0] LOW_LIMIT   = 32'd99999;
    localparam logic [31:0] HIGH_LIMIT  = 32'd999999;
    localparam int          RAND_CMDS   = 315;
    localparam int          IDLE_PCT    = 7;
    localparam int          HOLD_AFTER  = 600;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN       = 60;
    localparam int          LIMIT       = 200000;
    localparam int          MAX_PRINTS  = 50;

    // Seven-segment patterns, entry 0 in the lowest byte
    localparam logic [GLYPHS*8-1:0] GLYPH_ROM = {
        8'h00, 8'h37, 8'h5E, 8'h78, 8'h5C, 8'h7C, 8'h40, 8'h70, 8'h79,
        8'h3E, 8'h71, 8'h67, 8'h73, 8'h38, 8'h77, 8'h39, 8'h6F, 8'h7F,
        8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    // One word of a write frame
    typedef struct packed {
        logic       is_header;
        logic [8:0] frame_word;
        logic       last;
    } frame_word_t;

    // One directed command; with has_fill set, the frame is typed in as
    // sixteen copies of fill.
    typedef struct packed {
        action_t     act;
        logic [31:0] val;
        logic        has_fill;
        logic [7:0]  fill;
    } cmd_row_t;

    localparam int DIR_CMDS = 25;

    cmd_row_t dir_rows [DIR_CMDS] = '{
        '{ACT_REFRESH,   32'd0,          1'b1, 8'h00},
        '{ACT_LOW_AREA,  32'd0,          1'b0, 8'h00},
        '{ACT_HIGH_AREA, 32'd0,          1'b0, 8'h00},
        '{ACT_REFRESH,   32'd0,          1'b0, 8'h00},
        '{ACT_LOW_AREA,  32'd99999,      1'b0, 8'h00},
        '{ACT_HIGH_AREA, 32'd999999,     1'b0, 8'h00},
        '{ACT_REFRESH,   32'd0,          1'b0, 8'h00},
        '{ACT_LOW_AREA,  32'd100000,     1'b0, 8'h00},
        '{ACT_HIGH_AREA, 32'd1000000,    1'b0, 8'h00},
        '{ACT_REFRESH,   32'd0,          1'b0, 8'h00},
        '{ACT_LOW_AREA,  32'hFFFF_FFFF,  1'b0, 8'h00},
        '{ACT_HIGH_AREA, 32'hFFFF_FFFF,  1'b0, 8'h00},
        '{ACT_REFRESH,   32'd0,          1'b0, 8'h00},
        '{ACT_FILL_CHAR, 32'd0,          1'b0, 8'h00},
        '{ACT_FILL_CHAR, 32'd25,         1'b1, 8'h00},
        '{ACT_FILL_CHAR, 32'd26,         1'b1, 8'h00},
        '{ACT_FILL_CHAR, 32'hFFFF_FFFF,  1'b1, 8'h00},
        '{ACT_ALL_ON,    32'd0,          1'b1, 8'hFF},
        '{ACT_LOW_AREA,  32'd12345,      1'b0, 8'h00},
        '{ACT_REFRESH,   32'd0,          1'b0, 8'h00},
        '{ACT_UNUSED,    32'hA5A5_5A5A,  1'b0, 8'h00},
        '{ACT_REFRESH,   32'd0,          1'b0, 8'h00},
        '{ACT_BOOT,      32'h5A5A_A5A5,  1'b0, 8'h00},
        '{ACT_REFRESH,   32'd0,          1'b0, 8'h00},
        '{ACT_ALL_OFF,   32'hFFFF_FFFF,  1'b1, 8'h00}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value
    logic [2:0]  s_tuser  = '0;   // [2:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [8:0] frame_word, [15:9] zero
    logic [0:0]  m_tuser;         // [0] is_header
    logic        m_tlast;

    // Local copy of the segment store and the words still to come
    logic [7:0]  seg_store [NUM_BYTES];
    frame_word_t frame_q [$];

    logic no_idle = 1'b0;
    int   err_cnt = 0;
    int   cmds_sent = 0;
    int   frames_queued = 0;
    int   words_checked = 0;
    int   cycle_cnt = 0;
    int   hold_left = 0;
    logic held_once = 1'b0;

    segment_lcd_number_display i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Prints one line per mismatch, up to a cap, and counts all of them.
    task automatic report_mismatch(string msg);
        if (err_cnt < MAX_PRINTS) begin
            $display("MISMATCH at word %0d: %s", words_checked, msg);
        end
        err_cnt++;
    endtask

    // Segment pattern of a character code; codes past the table are blank.
    function automatic logic [7:0] glyph(logic [31:0] code);
        int unsigned idx;
        idx = (code >= GLYPHS) ? BLANK_IDX : int'(code);
        return GLYPH_ROM[idx*8 +: 8];
    endfunction

    // Applies one command to the store; returns 1 when it sends a frame.
    function automatic logic apply_action(action_t act, logic [31:0] val);
        logic [31:0] num;
        logic [31:0] lim;
        int          top;
        int          digs;
        case (act)
            ACT_LOW_AREA, ACT_HIGH_AREA: begin
                lim  = (act == ACT_LOW_AREA) ? LOW_LIMIT : HIGH_LIMIT;
                top  = (act == ACT_LOW_AREA) ? 9 : 15;
                digs = (act == ACT_LOW_AREA) ? 5 : 6;
                num  = (val > lim) ? lim : val;
                // Least significant digit lands in the top byte of the area.
                for (int k = 0; k < digs; k++) begin
                    seg_store[top-k] = glyph(num % 10);
                    num = num / 10;
                end
                return 1'b0;
            end
            ACT_FILL_CHAR: begin
                foreach (seg_store[i]) seg_store[i] = glyph(val);
                return 1'b1;
            end
            ACT_ALL_ON: begin
                foreach (seg_store[i]) seg_store[i] = 8'hFF;
                return 1'b1;
            end
            ACT_ALL_OFF: begin
                foreach (seg_store[i]) seg_store[i] = 8'h00;
                return 1'b1;
            end
            ACT_BOOT: begin
                foreach (seg_store[i]) seg_store[i] = glyph(i);
                return 1'b0;
            end
            ACT_REFRESH: begin
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // Queues the header and the store bytes from the top index down.
    function automatic void queue_frame(logic has_fill, logic [7:0] fill);
        frame_word_t w;
        w.is_header  = 1'b1;
        w.frame_word = HDR_WORD;
        w.last       = 1'b0;
        frame_q.push_back(w);
        for (int i = NUM_BYTES - 1; i >= 0; i--) begin
            w.is_header  = 1'b0;
            w.frame_word = {1'b0, has_fill ? fill : seg_store[i]};
            w.last       = (i == 0);
            frame_q.push_back(w);
        end
        frames_queued++;
    endfunction

    // Offers one command, waits for its transfer and records the result.
    task automatic send_cmd(action_t act, logic [31:0] val, logic has_fill,
                            logic [7:0] fill);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (apply_action(act, val)) begin
            queue_frame(has_fill, fill);
        end
        cmds_sent++;
    endtask

    // Compares one frame word with the oldest expectation.
    task automatic check_frame_word();
        frame_word_t want;
        if (frame_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word tdata=%h tuser=%b",
                                      m_tdata, m_tuser));
            return;
        end
        want = frame_q.pop_front();
        if (m_tuser[0] !== want.is_header)
            report_mismatch($sformatf("is_header %b, want %b", m_tuser[0],
                                      want.is_header));
        if (m_tdata !== {7'd0, want.frame_word})
            report_mismatch($sformatf("tdata %h, want %h", m_tdata,
                                      want.frame_word));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last));
        words_checked++;
    endtask

    // Output side: checks each transfer, stalls at random, and holds off
    // once for a long stretch so that the command channel backs up.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_frame_word();
            if (hold_left != 0) begin
                hold_left--;
            end else if (!held_once && words_checked >= HOLD_AFTER) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            m_tready <= (hold_left == 0) &&
                        (no_idle || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT) begin
            $display("Run limit of %0d cycles reached, %0d words pending.",
                     LIMIT, frame_q.size());
            $display("[segment_lcd_number_display] ERROR");
            $finish;
        end
    end

    // Picks a value that favors small codes and the saturation limits.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0:       return $urandom_range(30);
            1:       return $urandom_range(1000010, 99990);
            2:       return $urandom();
            default: return $urandom_range(999999);
        endcase
    endfunction

    function automatic action_t pick_action();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 22) return ACT_LOW_AREA;
        if (r < 44) return ACT_HIGH_AREA;
        if (r < 62) return ACT_REFRESH;
        if (r < 74) return ACT_FILL_CHAR;
        if (r < 80) return ACT_ALL_ON;
        if (r < 86) return ACT_ALL_OFF;
        if (r < 94) return ACT_BOOT;
        return ACT_UNUSED;
    endfunction

    // Stimulus and end of run
    initial begin
        action_t act;
        int      n_rand;
        foreach (seg_store[i]) seg_store[i] = 8'h00;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[r]) begin
            send_cmd(dir_rows[r].act, dir_rows[r].val, dir_rows[r].has_fill,
                     dir_rows[r].fill);
        end

        n_rand = 0;
        while (n_rand < RAND_CMDS) begin
            // A stretch with no idling on either side
            no_idle <= (n_rand >= 120 && n_rand < 200);
            act = pick_action();
            send_cmd(act, pick_value(), 1'b0, 8'h00);
            if (act != ACT_UNUSED) n_rand++;
        end
        s_tvalid <= 1'b0;

        while (frame_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("Sent %0d commands (%0d directed), checked %0d frame words in %0d frames.",
                 cmds_sent, DIR_CMDS, words_checked, frames_queued);
        $display("Output held off once for %0d cycles; %0d mismatches.",
                 HOLD_CYCLES, err_cnt);
        if (err_cnt == 0) begin
            $display("[segment_lcd_number_display] OK");
        end else begin
            $display("[segment_lcd_number_display] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/sld_pkg.sv
hw/rtl/sld_div10.sv
hw/rtl/segment_lcd_number_display.sv
dv/segment_lcd_number_display_tb.sv
